// File: rtl/gsa_pkg.sv
// Shared constants and types for the Gaussian shadow alpha unit.
// No dependencies; imported by gsa_walk, gsa_accum and the top level.
package gsa_pkg;

  localparam int MAX_KERNEL_SIDE = 64;
  localparam int COEF_FRAC_BITS  = 16;

  localparam int STORE_DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SIDE_W      = $clog2(MAX_KERNEL_SIDE + 1);

  localparam int CFG_SIDE_W = 7;
  localparam int OPAC_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int IDX_W      = 12;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 16;
  localparam int WIN_W      = 15;
  localparam int ALPHA_W    = 8;

  localparam int CLIP_W = 18;

  localparam int SUM_RAW_W = COEF_W + ADDR_W;
  localparam int ACC_W     = (SUM_RAW_W > COEF_FRAC_BITS + 1) ? SUM_RAW_W : COEF_FRAC_BITS + 1;
  localparam int CLAMP_W   = COEF_FRAC_BITS + 1;
  localparam int PROD_W    = CLAMP_W + OPAC_W;
  localparam int SCALE_W   = PROD_W + 8;
  localparam int SHIFT     = COEF_FRAC_BITS + 16;
  localparam int RES_W     = SCALE_W - SHIFT;

  typedef enum logic {
    CFG_KERNEL_SIDE    = 1'b0,
    CFG_SHADOW_OPACITY = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE_COEF = 1'b0,
    OP_QUERY      = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_BASE,
    ST_WALK,
    ST_DRAIN
  } walk_state_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic last;
  } walk_req_t;

endpackage

// File: rtl/gsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/gsa_walk.sv
// Query sequencer: clips the centered kernel to the window and walks the
// clipped rectangle of the kernel store, one read per cycle. Uses gsa_pkg.
module gsa_walk
  import gsa_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [CFG_SIDE_W-1:0]       side,
  input  logic                        q_start,
  input  logic signed [POS_W-1:0]     px,
  input  logic signed [POS_W-1:0]     py,
  input  logic [WIN_W-1:0]            w,
  input  logic [WIN_W-1:0]            h,
  input  logic                        done,
  output logic                        busy,
  output walk_req_t                   req,
  output logic [ADDR_W-1:0]           rd_addr
);

  walk_state_t state_r, state_nxt;

  logic signed [POS_W-1:0] px_r, py_r;
  logic [WIN_W-1:0]        w_r, h_r;
  logic [SIDE_W-1:0]       side_r, side_nxt;
  logic [SIDE_W-1:0]       xs_r, xe_r, ys_r, ye_r;
  logic [SIDE_W-1:0]       xs_nxt, xe_nxt, ys_nxt, ye_nxt;
  logic [SIDE_W-1:0]       col_r, col_nxt, row_r, row_nxt;
  logic [ADDR_W-1:0]       base_r, base_nxt;

  logic [SIDE_W-1:0]       side_eff;
  logic signed [CLIP_W-1:0] cen_s, px_s, py_s, w_s, h_s;

  function automatic logic [SIDE_W-1:0] clip_side(input logic signed [CLIP_W-1:0] v,
                                                  input logic [SIDE_W-1:0] s);
    logic signed [CLIP_W-1:0] s_ext;
    s_ext = CLIP_W'(s);
    if (v < 0) begin
      return '0;
    end else if (v > s_ext) begin
      return s;
    end else begin
      return v[SIDE_W-1:0];
    end
  endfunction

  always_comb begin
    if (32'(side) > 32'(MAX_KERNEL_SIDE)) begin
      side_eff = SIDE_W'(MAX_KERNEL_SIDE);
    end else begin
      side_eff = SIDE_W'(side);
    end
    cen_s = CLIP_W'(side_eff >> 1);
    px_s  = CLIP_W'(px_r);
    py_s  = CLIP_W'(py_r);
    w_s   = CLIP_W'(w_r);
    h_s   = CLIP_W'(h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_start) begin
      px_r <= px;
      py_r <= py;
      w_r  <= w;
      h_r  <= h;
    end
    side_r <= side_nxt;
    xs_r   <= xs_nxt;
    xe_r   <= xe_nxt;
    ys_r   <= ys_nxt;
    ye_r   <= ye_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    base_r <= base_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    xs_nxt    = xs_r;
    xe_nxt    = xe_r;
    ys_nxt    = ys_r;
    ye_nxt    = ye_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    req       = '0;
    rd_addr   = base_r + ADDR_W'(col_r);
    unique case (state_r)
      ST_IDLE: begin
        if (q_start) begin
          state_nxt = ST_CLIP;
        end
      end
      ST_CLIP: begin
        req.clear = 1'b1;
        side_nxt  = side_eff;
        xs_nxt    = clip_side(cen_s - px_s, side_eff);
        xe_nxt    = clip_side(w_s + cen_s - px_s, side_eff);
        ys_nxt    = clip_side(cen_s - py_s, side_eff);
        ye_nxt    = clip_side(h_s + cen_s - py_s, side_eff);
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        if (xs_r >= xe_r || ys_r >= ye_r) begin
          req.last  = 1'b1;
          state_nxt = ST_DRAIN;
        end else begin
          base_nxt  = ADDR_W'(ys_r) * ADDR_W'(side_r);
          col_nxt   = xs_r;
          row_nxt   = ys_r;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        req.rd_en = 1'b1;
        if (col_r == xe_r - SIDE_W'(1)) begin
          col_nxt  = xs_r;
          row_nxt  = row_r + SIDE_W'(1);
          base_nxt = base_r + ADDR_W'(side_r);
          if (row_r == ye_r - SIDE_W'(1)) begin
            req.last  = 1'b1;
            state_nxt = ST_DRAIN;
          end
        end else begin
          col_nxt = col_r + SIDE_W'(1);
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTH
  a_read_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> state_r == ST_WALK)
    else $error("kernel read outside walk");

  a_last_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
    req.last |=> state_r == ST_DRAIN)
    else $error("last read not followed by drain");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_DRAIN)
    else $error("result strobe outside drain");
`endif

endmodule

// File: rtl/gsa_accum.sv
// Accumulator and output scaler: sums kernel reads, saturates at 1.0 and
// scales by opacity and 255 over a short pipeline. Uses gsa_pkg.
module gsa_accum
  import gsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  walk_req_t          req,
  input  logic [COEF_W-1:0]  rd_data,
  input  logic [OPAC_W-1:0]  opacity,
  output logic               out_valid,
  output logic [ALPHA_W-1:0] alpha
);

  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << COEF_FRAC_BITS;

  logic               rd_d1_r, last_d1_r, last_d2_r, v1_r, v2_r, out_valid_r;
  logic [ACC_W-1:0]   sum_r;
  logic [CLAMP_W-1:0] sum_sat;
  logic [PROD_W-1:0]  prod_r;
  logic [SCALE_W-1:0] scale_r;
  logic [RES_W-1:0]   res;
  logic [ALPHA_W-1:0] alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_d1_r     <= 1'b0;
      last_d1_r   <= 1'b0;
      last_d2_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_d1_r     <= req.rd_en;
      last_d1_r   <= req.last;
      last_d2_r   <= last_d1_r;
      v1_r        <= last_d2_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_comb begin
    if (sum_r > ONE) begin
      sum_sat = CLAMP_W'(ONE);
    end else begin
      sum_sat = CLAMP_W'(sum_r);
    end
    res = RES_W'(scale_r >> SHIFT);
  end

  always_ff @(posedge clk) begin
    if (req.clear) begin
      sum_r <= '0;
    end else if (rd_d1_r) begin
      sum_r <= sum_r + ACC_W'(rd_data);
    end
    prod_r  <= PROD_W'(sum_sat) * PROD_W'(opacity);
    scale_r <= (SCALE_W'(prod_r) << 8) - SCALE_W'(prod_r);
    if (res > RES_W'(255)) begin
      alpha_r <= '1;
    end else begin
      alpha_r <= ALPHA_W'(res);
    end
  end

  assign out_valid = out_valid_r;
  assign alpha     = alpha_r;

`ifndef SYNTH
  a_no_read_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_d1_r |-> !req.rd_en)
    else $error("read issued after last read");

  a_strobe_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_d2_r |=> ##2 out_valid_r)
    else $error("result missing after last read");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// File: rtl/gaussian_shadow_alpha_unit.sv
// Top level of the Gaussian shadow alpha unit: configuration registers,
// kernel store and query datapath. Uses gsa_pkg, gsa_ram, gsa_walk, gsa_accum.
//
// Usage:
//   Input: drive the in_ fields and raise start; the item transfers at a clock
//   edge where start is high and busy is low. Operation write-coefficient
//   stores one kernel coefficient at that edge and gives no result; busy stays
//   low, so writes can follow every cycle. A query raises busy until its
//   result has been delivered.
//   Result: out_alpha is valid for exactly one cycle while out_valid is high;
//   the receiver cannot stall, the value must be taken in that cycle.
//   Query: the walker clips the centered kernel to the window and reads each
//   kernel coefficient inside the clipped window; the sum is saturated and
//   scaled by opacity and 255. The kernel store read port, one coefficient per
//   cycle, sets the rate; the next item transfers in the cycle after out_valid.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index at the
//   clock edge; write only while busy is low.
//   Reset: rst_n, synchronous, returns side to 37 and opacity to 1.0 and drops
//   any query in flight. Kernel store contents are undefined until written.
module gaussian_shadow_alpha_unit
  import gsa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [IDX_W-1:0]        in_coef_index,
  input  logic [COEF_W-1:0]       in_coef_value,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [WIN_W-1:0]        in_win_width,
  input  logic [WIN_W-1:0]        in_win_height,
  output logic                    out_valid,
  output logic [ALPHA_W-1:0]      out_alpha,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic [CFG_SIDE_W-1:0] kernel_side_r;
  logic [OPAC_W-1:0]     shadow_opacity_r;

  logic              accept, wr_accept, q_start;
  logic              walk_busy;
  walk_req_t         req;
  logic [ADDR_W-1:0] rd_addr;
  logic [COEF_W-1:0] rd_data;
  logic              done;

  assign accept    = start && !walk_busy;
  assign wr_accept = accept && (op_t'(in_operation) == OP_WRITE_COEF)
                     && (32'(in_coef_index) < 32'(STORE_DEPTH));
  assign q_start   = accept && (op_t'(in_operation) == OP_QUERY);
  assign busy      = walk_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_side_r    <= CFG_SIDE_W'(37);
      shadow_opacity_r <= OPAC_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KERNEL_SIDE:    kernel_side_r    <= cfg_wdata[CFG_SIDE_W-1:0];
        CFG_SHADOW_OPACITY: shadow_opacity_r <= cfg_wdata[OPAC_W-1:0];
        default: ;
      endcase
    end
  end

  gsa_ram #(
    .WIDTH(COEF_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_accept),
    .waddr(ADDR_W'(in_coef_index)),
    .wdata(in_coef_value),
    .re   (req.rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  gsa_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .side   (kernel_side_r),
    .q_start(q_start),
    .px     (in_pos_x),
    .py     (in_pos_y),
    .w      (in_win_width),
    .h      (in_win_height),
    .done   (done),
    .busy   (walk_busy),
    .req    (req),
    .rd_addr(rd_addr)
  );

  gsa_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_data  (rd_data),
    .opacity  (shadow_opacity_r),
    .out_valid(done),
    .alpha    (out_alpha)
  );

  assign out_valid = done;

endmodule
